FILE: hw/rtl/u2u_pkg.sv
package u2u_pkg;

  // Depth of the command queue between the decoder and the serializer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One decoded item: either a complete code point or an error marker.
  typedef struct packed {
    logic        err;
    logic        last;
    logic [20:0] cp;
  } cmd_t;

endpackage

FILE: hw/rtl/u2u_front.sv
module u2u_front import u2u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  logic [20:0] partial_point;
  logic [1:0]  bytes_left;
  logic [2:0]  sequence_length;
  logic        skipping;

  logic [20:0] partial_point_next;
  logic [1:0]  bytes_left_next;
  logic [2:0]  sequence_length_next;
  logic        skipping_next;

  logic [20:0] shifted;
  logic [1:0]  left_dec;
  logic        bad_value;
  logic        is_err;
  logic        is_point;
  logic [20:0] point;

  assign shifted  = {partial_point[14:0], text_byte[5:0]};
  assign left_dec = bytes_left - 2'd1;
  assign bad_value = ((sequence_length == 3'd2) && (shifted < 21'h80)) ||
                     ((sequence_length == 3'd3) && (shifted < 21'h800)) ||
                     ((sequence_length == 3'd4) &&
                      ((shifted < 21'h10000) || (shifted > 21'h10FFFF))) ||
                     (shifted[20:11] == 10'h01B);

  always_comb begin
    partial_point_next   = partial_point;
    bytes_left_next      = bytes_left;
    sequence_length_next = sequence_length;
    skipping_next        = skipping;
    is_err               = 1'b0;
    is_point             = 1'b0;
    point                = shifted;
    if (skipping) begin
      if (end_of_text) begin
        skipping_next = 1'b0;
      end
    end else if (bytes_left == 2'd0) begin
      if (text_byte < 8'h80) begin
        is_point = 1'b1;
        point    = {13'd0, text_byte};
      end else if (text_byte < 8'hC0 || text_byte >= 8'hF8) begin
        is_err = 1'b1;
      end else begin
        if (text_byte < 8'hE0) begin
          partial_point_next   = {16'd0, text_byte[4:0]};
          bytes_left_next      = 2'd1;
          sequence_length_next = 3'd2;
        end else if (text_byte < 8'hF0) begin
          partial_point_next   = {17'd0, text_byte[3:0]};
          bytes_left_next      = 2'd2;
          sequence_length_next = 3'd3;
        end else begin
          partial_point_next   = {18'd0, text_byte[2:0]};
          bytes_left_next      = 2'd3;
          sequence_length_next = 3'd4;
        end
        if (end_of_text) begin
          is_err = 1'b1;
        end
      end
    end else if (text_byte[7:6] != 2'b10) begin
      is_err = 1'b1;
    end else begin
      partial_point_next = shifted;
      bytes_left_next    = left_dec;
      if (left_dec != 2'd0) begin
        if (end_of_text) begin
          is_err = 1'b1;
        end
      end else if (bad_value) begin
        is_err = 1'b1;
      end else begin
        is_point             = 1'b1;
        partial_point_next   = '0;
        sequence_length_next = 3'd0;
      end
    end
    if (is_err) begin
      partial_point_next   = '0;
      bytes_left_next      = 2'd0;
      sequence_length_next = 3'd0;
      skipping_next        = ~end_of_text;
    end
  end

  assign cmd_valid = accept && (is_err || is_point);
  assign cmd.err   = is_err;
  assign cmd.last  = end_of_text;
  assign cmd.cp    = is_err ? 21'd0 : point;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point   <= '0;
      bytes_left      <= '0;
      sequence_length <= '0;
      skipping        <= 1'b0;
    end else if (accept) begin
      partial_point   <= partial_point_next;
      bytes_left      <= bytes_left_next;
      sequence_length <= sequence_length_next;
      skipping        <= skipping_next;
    end
  end

endmodule

FILE: hw/rtl/u2u_queue.sv
module u2u_queue import u2u_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  cmd_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (count == QueueCntW'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/u2u_back.sv
module u2u_back import u2u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       low_first,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       bad_input,
  output logic       run_last,
  output logic       text_done
);

  logic        busy;
  logic [1:0]  idx;
  logic        cur_err;
  logic        cur_last;
  logic        cur_pair;
  logic [15:0] unit0;
  logic [15:0] unit1;

  logic [19:0] offset;
  logic        load_pair;
  logic [1:0]  last_idx;
  logic        at_last;
  logic        take_out;
  logic [15:0] sel_unit;

  // Only points of 0x10000 and up use the offset, and those fit in 20 bits
  // after the subtraction.
  assign offset    = cmd.cp[19:0] - 20'h10000;
  assign load_pair = (cmd.cp[20:16] != 5'd0);

  assign last_idx = cur_err ? 2'd0 : (cur_pair ? 2'd3 : 2'd1);
  assign at_last  = (idx == last_idx);
  assign take_out = pop && busy;
  assign cmd_take = cmd_valid && (!busy || (take_out && at_last));

  assign empty     = ~busy;
  assign sel_unit  = idx[1] ? unit1 : unit0;
  assign out_byte  = cur_err ? 8'd0 :
                     ((idx[0] ^ low_first) ? sel_unit[7:0] : sel_unit[15:8]);
  assign bad_input = cur_err;
  assign run_last  = at_last;
  assign text_done = at_last && (cur_last || cur_err);

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_err  <= cmd.err;
      cur_last <= cmd.last;
      cur_pair <= load_pair && !cmd.err;
      unit0    <= load_pair ? {6'b110110, offset[19:10]} : cmd.cp[15:0];
      unit1    <= {6'b110111, offset[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (cmd_take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take_out) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder. Bytes of UTF-8 text are pushed in one per item,
// with end_of_text set on the final byte; UTF-16 bytes come out one per item,
// two for a code point in the basic plane and four for a surrogate pair, in
// the byte order held in the byte order register, written through cfg_write
// and cfg_data (reset value 1, low byte first; 0 gives high byte first).
// Invalid input (stray continuation bytes, leads 0xF8 and above, bad
// continuations, overlong forms, surrogates, values above 0x10FFFF, and a
// sequence cut off by the end of the text) gives a single item with
// bad_input set and out_byte zero, and the rest of that text is dropped up
// to and including its final byte. The decoder takes one input byte per cycle
// while the command queue is not full, and feeds that four-entry queue; the
// serializer behind it sends out one byte per cycle while pop is held and it
// has an item. An item is written into the queue as the input byte that
// completes it is accepted, and is loaded into the serializer's registers
// before its first output byte is on the ports. Write the byte order only
// while the block is idle.
module utf8_to_utf16_transcoder import u2u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       bad_input,
  output logic       run_last,
  output logic       text_done,
  input  logic       cfg_write,
  input  logic       cfg_data
);

  logic low_first;
  logic accept;
  logic front_valid;
  cmd_t front_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  // Byte order register; the serializer reads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_first <= 1'b1;
    end else if (cfg_write) begin
      low_first <= cfg_data;
    end
  end

  // An item is taken whenever the queue has room for the command it might
  // produce, so the decoder never waits on the output side directly.
  assign accept = push && !full;

  u2u_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd)
  );

  u2u_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  u2u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .low_first (low_first),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .bad_input (bad_input),
    .run_last  (run_last),
    .text_done (text_done)
  );

endmodule

FILE: verif/utf8_to_utf16_transcoder_test.sv
module utf8_to_utf16_transcoder_test;

  // One UTF-8 byte as it goes into the block, and one UTF-16 output item as it
  // comes out. The output struct keeps the port order so that a whole item can
  // be compared at once and printed field by field.
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } utf8_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       run_end;
    logic       text_end;
  } utf16_item_t;

  // The error item is the same every time: zero byte, all three flags set.
  localparam utf16_item_t ErrorItem = '{data: 8'h00, bad: 1'b1, run_end: 1'b1, text_end: 1'b1};

  // Kinds of damage that a random text may carry.
  typedef enum int {
    FlawNone,
    FlawOverlong,
    FlawSurrogate,
    FlawAboveRange,
    FlawBadContinuation,
    FlawCutOff,
    FlawBadLead
  } flaw_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       pop = 1'b0;
  logic       empty;
  logic [7:0] out_byte;
  logic       bad_input;
  logic       run_last;
  logic       text_done;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;

  utf8_to_utf16_transcoder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .bad_input   (bad_input),
    .run_last    (run_last),
    .text_done   (text_done),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Bytes still to be pushed, and the UTF-16 items that the accepted bytes
  // must produce, oldest first.
  utf8_byte_t  utf8_pending[$];
  utf16_item_t utf16_expected[$];

  // While calm is set neither side idles; this gives one long stretch of
  // back-to-back traffic in the last phase.
  logic calm = 1'b0;

  // Predictor state: the code point gathered so far, continuation bytes still
  // owed, the length of the sequence in progress, and whether the rest of the
  // current text is being dropped after an error.
  logic [20:0] dec_point = '0;
  logic [1:0]  dec_left = '0;
  logic [2:0]  dec_len = '0;
  logic        dropping = 1'b0;
  logic        low_first = 1'b1;

  int unsigned queued_bytes = 0;
  int unsigned bytes_in = 0;
  int unsigned bytes_out = 0;
  int unsigned error_items = 0;
  int unsigned surrogate_pairs = 0;
  int unsigned config_writes = 0;
  int unsigned mismatches = 0;

  utf8_byte_t  next_byte;
  utf16_item_t want_item;
  utf16_item_t got_item;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One UTF-16 code unit becomes two output items in the configured order. Only
  // the second one can close the byte's run, and it closes the text only when
  // the input byte was flagged as the end of the text.
  task automatic queue_unit(input logic [15:0] unit, input logic closes_run, input logic eot);
    utf16_item_t item;
    item = '{data: low_first ? unit[7:0] : unit[15:8], bad: 1'b0,
             run_end: 1'b0, text_end: 1'b0};
    utf16_expected.push_back(item);
    item = '{data: low_first ? unit[15:8] : unit[7:0], bad: 1'b0,
             run_end: closes_run, text_end: closes_run & eot};
    utf16_expected.push_back(item);
  endtask

  // Code points above the basic plane are split into a high and a low
  // surrogate; everything else is one unit.
  task automatic queue_point(input logic [20:0] cp, input logic eot);
    logic [19:0] offset;
    if (cp <= 21'h00FFFF) begin
      queue_unit(cp[15:0], 1'b1, eot);
    end else begin
      offset = 20'(cp - 21'h010000);
      queue_unit(16'hD800 + {6'd0, offset[19:10]}, 1'b0, eot);
      queue_unit(16'hDC00 + {6'd0, offset[9:0]}, 1'b1, eot);
      surrogate_pairs++;
    end
  endtask

  // An error wipes the decoder. If the text is not over yet, the rest of it is
  // dropped up to its flagged final byte.
  task automatic queue_error(input logic eot);
    dec_point = '0;
    dec_left = '0;
    dec_len = '0;
    dropping = !eot;
    utf16_expected.push_back(ErrorItem);
    error_items++;
  endtask

  task automatic predict_utf16(input logic [7:0] b, input logic eot);
    logic [20:0] cp;
    logic        invalid;
    if (dropping) begin
      if (eot) dropping = 1'b0;
    end else if (dec_left == 2'd0) begin
      // A lead byte is expected here.
      if (b < 8'h80) begin
        queue_point({13'd0, b}, eot);
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        // A stray continuation byte or a lead that no valid sequence uses.
        queue_error(eot);
      end else begin
        if (b < 8'hE0) begin
          dec_point = {16'd0, b[4:0]};
          dec_left = 2'd1;
          dec_len = 3'd2;
        end else if (b < 8'hF0) begin
          dec_point = {17'd0, b[3:0]};
          dec_left = 2'd2;
          dec_len = 3'd3;
        end else begin
          dec_point = {18'd0, b[2:0]};
          dec_left = 2'd3;
          dec_len = 3'd4;
        end
        // A lead on the final byte leaves the sequence cut off.
        if (eot) queue_error(eot);
      end
    end else if (b[7:6] != 2'b10) begin
      queue_error(eot);
    end else begin
      dec_point = {dec_point[14:0], b[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left != 2'd0) begin
        if (eot) queue_error(eot);
      end else begin
        // Sequence complete: reject overlong forms, surrogates and values
        // beyond the last plane before anything is emitted.
        cp = dec_point;
        invalid = (dec_len == 3'd2 && cp < 21'h000080) ||
                  (dec_len == 3'd3 && cp < 21'h000800) ||
                  (dec_len == 3'd4 && (cp < 21'h010000 || cp > 21'h10FFFF)) ||
                  (cp >= 21'h00D800 && cp <= 21'h00DFFF);
        dec_point = '0;
        dec_len = '0;
        if (invalid) queue_error(eot);
        else queue_point(cp, eot);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: the prediction is made at the edge where the byte is taken, so it
  // always sees the byte order that was in force for that byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_utf16(text_byte, end_of_text);
        bytes_in++;
      end
      if (push && full) begin
        // Held: the same byte stays on the ports until it is taken.
      end else if (utf8_pending.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        next_byte = utf8_pending.pop_front();
        push <= 1'b1;
        text_byte <= next_byte.data;
        end_of_text <= next_byte.eot;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every item taken from the block is checked against the oldest
  // prediction. Only the first few differences are printed.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input utf16_item_t want,
                                 input utf16_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at output item %0d: expected byte %h bad %b run_last %b ",
               what, bytes_out, want.data, want.bad, want.run_end,
               "text_done %b, got byte %h bad %b run_last %b text_done %b",
               want.text_end, got.data, got.bad, got.run_end, got.text_end);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_item = '{data: out_byte, bad: bad_input, run_end: run_last,
                     text_end: text_done};
        if (utf16_expected.size() == 0) begin
          report_mismatch("nothing expected", '0, got_item);
        end else begin
          want_item = utf16_expected.pop_front();
          if (got_item !== want_item) report_mismatch("wrong field", want_item, got_item);
        end
        bytes_out++;
      end
      pop <= calm || ($urandom_range(99) >= 31);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic eot);
    utf8_pending.push_back('{data: b, eot: eot});
    queued_bytes++;
  endtask

  // Encode cp in len bytes, whether or not len is the shortest form, and send
  // only the first keep of them. The end-of-text flag goes on the last byte
  // actually sent, so keep < len gives a cut-off sequence.
  task automatic add_utf8(input logic [20:0] cp, input int len, input int keep,
                          input logic eot);
    logic [7:0] seq [4];
    seq[1] = {2'b10, cp[17:12]};
    seq[2] = {2'b10, cp[11:6]};
    seq[3] = {2'b10, cp[5:0]};
    case (len)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (int i = 0; i < keep; i++) add_byte(seq[i], eot && (i == keep - 1));
  endtask

  // A valid code point from one of the four encoding lengths, surrogates
  // moved out of the way.
  function automatic logic [20:0] pick_point();
    logic [20:0] cp;
    case ($urandom_range(3))
      0: cp = 21'($urandom_range(0, 21'h7F));
      1: cp = 21'($urandom_range(21'h80, 21'h7FF));
      2: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp + 21'h800;
      end
      default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic int utf8_length(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic add_flaw(input flaw_t kind, input logic eot);
    int          len;
    int          keep;
    logic [20:0] cp;
    len = $urandom_range(2, 4);
    keep = $urandom_range(1, len - 1);
    cp = 21'($urandom);
    case (kind)
      FlawOverlong: begin
        cp = 21'($urandom_range(0, len == 2 ? 21'h7F : (len == 3 ? 21'h7FF : 21'hFFFF)));
        add_utf8(cp, len, len, eot);
      end
      FlawSurrogate: add_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3, eot);
      FlawAboveRange: add_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, eot);
      FlawBadContinuation: begin
        add_utf8(cp, len, keep, 1'b0);
        add_byte($urandom_range(1) ? 8'($urandom_range(0, 8'h7F)) :
                 8'($urandom_range(8'hC0, 8'hFF)), eot);
      end
      FlawCutOff: add_utf8(cp, len, keep, eot);
      default: begin
        add_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF)) :
                 8'($urandom_range(8'hF8, 8'hFF)), eot);
      end
    endcase
  endtask

  // One random text. Most are well formed; some carry a single flaw at a random
  // point, and a few are plain noise bytes.
  task automatic add_text();
    int          points;
    int          flaw_at;
    flaw_t       flaw;
    logic [20:0] cp;
    points = $urandom_range(1, 6);
    flaw_at = $urandom_range(0, points - 1);
    flaw = ($urandom_range(99) < 30) ? flaw_t'($urandom_range(FlawOverlong, FlawBadLead))
                                     : FlawNone;
    if ($urandom_range(99) < 10) begin
      for (int i = 0; i < points; i++) add_byte(8'($urandom), i == points - 1);
    end else begin
      for (int i = 0; i < points; i++) begin
        if (i == flaw_at && flaw != FlawNone) begin
          add_flaw(flaw, i == points - 1);
        end else begin
          cp = pick_point();
          add_utf8(cp, utf8_length(cp), utf8_length(cp), i == points - 1);
        end
      end
    end
  endtask

  task automatic add_random_texts(input int unsigned count);
    int unsigned first;
    first = queued_bytes;
    while (queued_bytes - first < count) add_text();
  endtask

  // Wait until every byte is in and every predicted item is out, then a few
  // more cycles in case the last bytes were dropped ones still in flight.
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while ((utf8_pending.size() != 0 || push || utf16_expected.size() != 0) &&
           guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_byte_order(input logic le);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= le;
    @(posedge clk);
    cfg_write <= 1'b0;
    low_first = le;
    config_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed texts in the reset byte order (low byte first).
    add_byte(8'h00, 1'b0);                         // smallest byte value
    add_utf8(21'h000080, 2, 2, 1'b0);              // smallest two-byte point
    add_utf8(21'h00FFFF, 3, 3, 1'b0);              // top of the basic plane
    add_utf8(21'h10FFFF, 4, 4, 1'b1);              // highest point, surrogate pair
    add_byte(8'h80, 1'b0);                         // stray continuation as lead
    add_byte(8'h41, 1'b1);                         // dropped, ends the text
    add_byte(8'hFF, 1'b1);                         // lead above 0xF7 on the final byte
    add_utf8(21'h000000, 2, 2, 1'b1);              // overlong two-byte form
    add_utf8(21'h00D800, 3, 3, 1'b1);              // encoded surrogate
    add_utf8(21'h110000, 4, 4, 1'b1);              // just above the last plane
    add_byte(8'hE2, 1'b0);                         // bad continuation byte
    add_byte(8'h41, 1'b1);
    add_byte(8'hC2, 1'b1);                         // sequence cut off by the end
    wait_idle();

    // Random texts, switching byte order between phases. The last phase runs
    // with both sides busy every cycle.
    set_byte_order(1'b0);
    add_random_texts(130);
    wait_idle();

    set_byte_order(1'b1);
    add_random_texts(120);
    wait_idle();

    set_byte_order(1'b0);
    calm <= 1'b1;
    add_random_texts(110);
    wait_idle();

    if (utf16_expected.size() != 0) begin
      $display("%0d predicted output items never came out", utf16_expected.size());
      mismatches += utf16_expected.size();
    end

    $display("Covered %0d UTF-8 bytes in, %0d UTF-16 items out, %0d errors, ",
             bytes_in, bytes_out, error_items,
             "%0d surrogate pairs, %0d byte order writes.", surrogate_pairs, config_writes);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_transcoder_test: PASS");
    end else begin
      $display("utf8_to_utf16_transcoder_test: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("utf8_to_utf16_transcoder_test: FAIL");
    $finish;
  end

endmodule
